// ----- rtl/erv_pkg.sv -----
package erv_pkg;

    typedef enum logic [1:0] {
        OP_ENC  = 2'd0,
        OP_MUTE = 2'd1,
        OP_SET  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHMUTE  = 2'd3;

    localparam logic [1:0] CHM_LEFT  = 2'd1;
    localparam logic [1:0] CHM_RIGHT = 2'd2;

    localparam int COUNT_W = 32;
    localparam int DIV_W   = 32;
    localparam int VOL_W   = 11;

    localparam logic signed [VOL_W-1:0] VOL_MIN = -11'sd755;
    localparam logic signed [VOL_W-1:0] VOL_MAX = 11'sd120;
    localparam logic signed [VOL_W-1:0] GAIN_LO = -11'sd120;

    localparam logic signed [4:0] BOOST_UP   = 5'sd12;
    localparam logic signed [4:0] BOOST_DOWN = -5'sd12;

    localparam logic [1:0] PINS_LOW  = 2'b01;
    localparam logic [1:0] PINS_NONE = 2'b00;
    localparam logic [1:0] PINS_HIGH = 2'b10;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic mul;
        logic apply;
        logic eff;
        logic gain;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic op_enc;
    } t_sts;

endpackage

// ----- rtl/encoder_relay_volume_control.sv -----
// An encoder sample steps through the prepare, bit-serial quotient loop, multiply,
// apply, effective-level, gain and emit states; mute toggle, volume set and the
// unused code skip both. A new item is taken only after the last one is emitted.
// A finished result waits in the output register while the next item is accepted.
// Reset (synchronous, active low): volume 0 dB, count 0, unmuted, gain pins off,
// ticks per step 4, step 0.5 dB, balance 0, both channels on; no clearing pass.
module encoder_relay_volume_control #(
    parameter int CODE_BITS = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_operation,
    input  logic signed [erv_pkg::COUNT_W-1:0]   i_encoder_count,
    input  logic signed [15:0]                   i_volume_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [CODE_BITS-1:0]                 o_left_code,
    output logic [CODE_BITS-1:0]                 o_right_code,
    output logic                                 o_low_gain_on,
    output logic                                 o_high_gain_on,
    output logic signed [erv_pkg::VOL_W-1:0]     o_volume_now,
    output logic                                 o_muted_now,
    output logic                                 o_changed,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [erv_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [erv_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    erv_pkg::t_cmd cmd;
    erv_pkg::t_sts sts;

    assign o_cfg_ready = i_rst_n;

    erv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    erv_dp #(
        .CODE_BITS (CODE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_encoder_count (i_encoder_count),
        .i_volume_value  (i_volume_value),
        .o_left_code     (o_left_code),
        .o_right_code    (o_right_code),
        .o_low_gain_on   (o_low_gain_on),
        .o_high_gain_on  (o_high_gain_on),
        .o_volume_now    (o_volume_now),
        .o_muted_now     (o_muted_now),
        .o_changed       (o_changed)
    );

endmodule

// ----- rtl/erv_ctrl.sv -----
module erv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  erv_pkg::t_sts     i_sts,
    output erv_pkg::t_cmd     o_cmd
);

    localparam int CNT_W = $clog2(erv_pkg::DIV_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL,
        S_APPLY,
        S_EFF,
        S_GAIN,
        S_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    erv_pkg::t_cmd    n_cmd;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                n_cmd.prep = 1'b1;
                n_cnt      = CNT_W'(erv_pkg::DIV_W - 1);
                n_state    = i_sts.op_enc ? S_DIV : S_APPLY;
            end
            S_DIV: begin
                n_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_MUL;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_MUL: begin
                n_cmd.mul = 1'b1;
                n_state   = S_APPLY;
            end
            S_APPLY: begin
                n_cmd.apply = 1'b1;
                n_state     = S_EFF;
            end
            S_EFF: begin
                n_cmd.eff = 1'b1;
                n_state   = S_GAIN;
            end
            S_GAIN: begin
                n_cmd.gain = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = n_cmd;

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_PREP))
        else $error("accepted beat did not start preparation");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_MUL))
        else $error("division did not end after last step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(n_cmd.emit && r_out_valid && i_out_stall))
        else $error("result overwritten while stalled");

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_cmd.emit |=> (o_out_valid && !o_in_stall))
        else $error("emit did not present result and return idle");

endmodule

// ----- rtl/erv_dp.sv -----
module erv_dp #(
    parameter int CODE_BITS = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  erv_pkg::t_cmd                        i_cmd,
    output erv_pkg::t_sts                        o_sts,
    input  logic                                 i_cfg_we,
    input  logic [erv_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [erv_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [1:0]                           i_operation,
    input  logic signed [erv_pkg::COUNT_W-1:0]   i_encoder_count,
    input  logic signed [15:0]                   i_volume_value,
    output logic [CODE_BITS-1:0]                 o_left_code,
    output logic [CODE_BITS-1:0]                 o_right_code,
    output logic                                 o_low_gain_on,
    output logic                                 o_high_gain_on,
    output logic signed [erv_pkg::VOL_W-1:0]     o_volume_now,
    output logic                                 o_muted_now,
    output logic                                 o_changed
);

    localparam int CW = CODE_BITS + 4;
    localparam logic [CODE_BITS-1:0] CODE_MAX = '1;

    function automatic logic signed [8:0] div5(input logic signed [11:0] x);
        logic [11:0] mag;
        logic [17:0] prod;
        logic [7:0]  q;
        mag  = x[11] ? 12'(-x) : 12'(x);
        prod = 18'(mag[9:0]) * 18'd205;
        q    = prod[17:10];
        return x[11] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    function automatic logic signed [10:0] clamp_vol(input logic signed [18:0] v);
        if (v < erv_pkg::VOL_MIN) begin
            return erv_pkg::VOL_MIN;
        end else if (v > erv_pkg::VOL_MAX) begin
            return erv_pkg::VOL_MAX;
        end else begin
            return v[10:0];
        end
    endfunction

    logic [6:0]         r_tps, r_step;
    logic signed [8:0]  r_bal;
    logic [1:0]         r_chm;

    erv_pkg::t_op       r_op;
    logic [31:0]        r_count;
    logic signed [15:0] r_vol16;

    logic               r_neg;
    logic [31:0]        r_work;
    logic [6:0]         r_rem;
    logic signed [8:0]  r_lb5, r_rb5;
    logic [16:0]        r_prod;

    logic signed [10:0] r_mv;
    logic [31:0]        r_last;
    logic               r_mute;
    logic [1:0]         r_pins;
    logic               r_changed;

    logic signed [10:0] r_le, r_re;
    logic signed [8:0]  r_ql, r_qr;
    logic signed [4:0]  r_boost;

    logic [CODE_BITS-1:0] r_left, r_right;
    logic               r_low, r_high, r_mute_o, r_chg_o;
    logic signed [10:0] r_vol_o;

    logic [6:0]         tps_eff;
    logic [31:0]        d_fwd, d_bwd;
    logic signed [8:0]  hb, hmag9;
    logic [4:0]         m2;
    logic [5:0]         p1;
    logic [7:0]         m5, p5;
    logic [7:0]         div_t;
    logic               div_ge;
    logic [9:0]         qs;
    logic signed [18:0] step_sum;
    logic signed [10:0] mx;
    logic signed [CW-1:0] sl, sr;
    logic [CODE_BITS-1:0] code_l, code_r;

    always_comb begin
        tps_eff = (r_tps == '0) ? 7'd1 : r_tps;
        d_fwd   = r_count - r_last;
        d_bwd   = r_last - r_count;
        hb      = div5({{3{r_bal[8]}}, r_bal});
        hmag9   = hb[8] ? -hb : hb;
        m2      = hmag9[5:1];
        p1      = {1'b0, m2} + {5'b0, hmag9[0]};
        m5      = {1'b0, m2, 2'b00} + {3'b0, m2};
        p5      = {p1, 2'b00} + {2'b0, p1};
        div_t   = {r_rem, r_work[31]};
        div_ge  = (div_t >= {1'b0, tps_eff});
        qs      = (|r_work[31:10]) ? 10'h3FF : r_work[9:0];
        step_sum = r_neg ? $signed({{8{r_mv[10]}}, r_mv}) - $signed({2'b00, r_prod})
                         : $signed({{8{r_mv[10]}}, r_mv}) + $signed({2'b00, r_prod});
        mx      = (r_le > r_re) ? r_le : r_re;
        sl = $signed({{(CW-9){r_ql[8]}}, r_ql})
           - $signed({{(CW-6){r_boost[4]}}, r_boost, 1'b0})
           + $signed({{(CW-CODE_BITS){1'b0}}, CODE_MAX});
        sr = $signed({{(CW-9){r_qr[8]}}, r_qr})
           - $signed({{(CW-6){r_boost[4]}}, r_boost, 1'b0})
           + $signed({{(CW-CODE_BITS){1'b0}}, CODE_MAX});
        if (sl < 0) begin
            code_l = '0;
        end else if (sl > $signed({{(CW-CODE_BITS){1'b0}}, CODE_MAX})) begin
            code_l = CODE_MAX;
        end else begin
            code_l = sl[CODE_BITS-1:0];
        end
        if (sr < 0) begin
            code_r = '0;
        end else if (sr > $signed({{(CW-CODE_BITS){1'b0}}, CODE_MAX})) begin
            code_r = CODE_MAX;
        end else begin
            code_r = sr[CODE_BITS-1:0];
        end
        if (r_mute) begin
            code_l = '0;
            code_r = '0;
        end else if (r_chm == erv_pkg::CHM_LEFT) begin
            code_l = '0;
        end else if (r_chm == erv_pkg::CHM_RIGHT) begin
            code_r = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps     <= 7'd4;
            r_step    <= 7'd5;
            r_bal     <= '0;
            r_chm     <= '0;
            r_op      <= erv_pkg::OP_NONE;
            r_mv      <= '0;
            r_last    <= '0;
            r_mute    <= 1'b0;
            r_pins    <= erv_pkg::PINS_NONE;
            r_changed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    erv_pkg::CFG_TICKS:   r_tps  <= i_cfg_data[6:0];
                    erv_pkg::CFG_STEP:    r_step <= i_cfg_data[6:0];
                    erv_pkg::CFG_BALANCE: r_bal  <= $signed(i_cfg_data);
                    erv_pkg::CFG_CHMUTE:  r_chm  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_op <= erv_pkg::t_op'(i_operation);
            end
            if (i_cmd.apply) begin
                case (r_op)
                    erv_pkg::OP_ENC: begin
                        if (r_mute) begin
                            r_last    <= r_count;
                            r_changed <= 1'b0;
                        end else if (r_work == '0) begin
                            r_changed <= 1'b0;
                        end else begin
                            r_mv      <= clamp_vol(step_sum);
                            r_last    <= r_neg ? r_count + {25'b0, r_rem}
                                               : r_count - {25'b0, r_rem};
                            r_changed <= 1'b1;
                        end
                    end
                    erv_pkg::OP_MUTE: begin
                        r_mute    <= ~r_mute;
                        r_changed <= 1'b1;
                    end
                    erv_pkg::OP_SET: begin
                        r_mv      <= clamp_vol({{3{r_vol16[15]}}, r_vol16});
                        r_changed <= 1'b1;
                    end
                    default: begin
                        r_changed <= 1'b0;
                    end
                endcase
            end
            if (i_cmd.gain && !r_mute) begin
                if (mx < erv_pkg::GAIN_LO) begin
                    r_pins <= erv_pkg::PINS_LOW;
                end else if (mx <= 0) begin
                    r_pins <= erv_pkg::PINS_NONE;
                end else begin
                    r_pins <= erv_pkg::PINS_HIGH;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_count <= i_encoder_count;
            r_vol16 <= i_volume_value;
        end
        if (i_cmd.prep) begin
            r_neg  <= d_fwd[31];
            r_work <= d_fwd[31] ? d_bwd : d_fwd;
            r_rem  <= '0;
            r_lb5  <= hb[8] ? $signed({1'b0, p5}) : -$signed({1'b0, m5});
            r_rb5  <= hb[8] ? -$signed({1'b0, m5}) : $signed({1'b0, p5});
        end
        if (i_cmd.div_step) begin
            r_rem  <= div_ge ? 7'(div_t - {1'b0, tps_eff}) : div_t[6:0];
            r_work <= {r_work[30:0], div_ge};
        end
        if (i_cmd.mul) begin
            r_prod <= 17'(qs) * 17'(r_step);
        end
        if (i_cmd.eff) begin
            r_le <= clamp_vol($signed({{8{r_mv[10]}}, r_mv})
                              + $signed({{10{r_lb5[8]}}, r_lb5}));
            r_re <= clamp_vol($signed({{8{r_mv[10]}}, r_mv})
                              + $signed({{10{r_rb5[8]}}, r_rb5}));
        end
        if (i_cmd.gain) begin
            r_ql <= div5({r_le[10], r_le});
            r_qr <= div5({r_re[10], r_re});
            if (mx < erv_pkg::GAIN_LO) begin
                r_boost <= erv_pkg::BOOST_DOWN;
            end else if (mx <= 0) begin
                r_boost <= '0;
            end else begin
                r_boost <= erv_pkg::BOOST_UP;
            end
        end
        if (i_cmd.emit) begin
            r_left   <= code_l;
            r_right  <= code_r;
            r_low    <= r_pins[0];
            r_high   <= r_pins[1];
            r_vol_o  <= r_mv;
            r_mute_o <= r_mute;
            r_chg_o  <= r_changed;
        end
    end

    assign o_sts.op_enc   = (r_op == erv_pkg::OP_ENC);
    assign o_left_code    = r_left;
    assign o_right_code   = r_right;
    assign o_low_gain_on  = r_low;
    assign o_high_gain_on = r_high;
    assign o_volume_now   = r_vol_o;
    assign o_muted_now    = r_mute_o;
    assign o_changed      = r_chg_o;

    a_vol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mv >= erv_pkg::VOL_MIN && r_mv <= erv_pkg::VOL_MAX))
        else $error("master volume outside clamp range");

    a_pins_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pins != 2'b11)
        else $error("both gain pins set");

    a_mute_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_mute) |=> (r_left == '0 && r_right == '0 && r_mute_o))
        else $error("muted beat carries nonzero relay code");

endmodule

// ----- bench/encoder_relay_volume_control_tb.sv -----
`timescale 1ns / 100ps

module encoder_relay_volume_control_tb;

    localparam int CODE_BITS = 7;
    localparam int CODE_MAX  = (1 << CODE_BITS) - 1;

    typedef struct {
        logic [CODE_BITS-1:0]             left_code;
        logic [CODE_BITS-1:0]             right_code;
        logic                             low_gain;
        logic                             high_gain;
        logic signed [erv_pkg::VOL_W-1:0] volume;
        logic                             muted;
        logic                             changed;
    } t_relay_codes;

    class relay_scoreboard;
        logic [6:0]        ticks_per_step = 7'd4;
        logic [6:0]        step_tenths    = 7'd5;
        logic signed [8:0] balance        = 9'sd0;
        logic [1:0]        chan_mute      = 2'd0;

        int          volume     = 0;
        logic [31:0] last_count = 32'd0;
        logic        muted      = 1'b0;
        logic [1:0]  gain_pins  = erv_pkg::PINS_NONE;

        t_relay_codes codes_due[$];
        int           errors;
        int           checked;
        int           op_seen[4];
        int           reg_writes;

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void write_reg(logic [erv_pkg::CFG_IDX_W-1:0] idx,
                                logic [erv_pkg::CFG_DATA_W-1:0] data);
            reg_writes++;
            case (idx)
                erv_pkg::CFG_TICKS:   ticks_per_step = data[6:0];
                erv_pkg::CFG_STEP:    step_tenths    = data[6:0];
                erv_pkg::CFG_BALANCE: balance        = data;
                erv_pkg::CFG_CHMUTE:  chan_mute      = data[1:0];
                default: ;
            endcase
        endfunction

        function logic encoder_move(logic [31:0] count);
            logic [31:0] delta;
            logic [31:0] tps;
            logic [31:0] mag;
            logic [31:0] steps;
            logic        neg;
            longint      moved;
            delta = count - last_count;
            tps   = (ticks_per_step == 7'd0) ? 32'd1 : {25'd0, ticks_per_step};
            neg   = delta[31];
            mag   = neg ? (32'd0 - delta) : delta;
            if (delta == 32'd0)
                return 1'b0;
            if (muted) begin
                last_count = count;
                return 1'b0;
            end
            steps = mag / tps;
            if (steps == 32'd0)
                return 1'b0;
            moved = longint'(steps) * longint'(step_tenths);
            if (neg) begin
                volume     = int'(clip(longint'(volume) - moved,
                                       erv_pkg::VOL_MIN, erv_pkg::VOL_MAX));
                last_count = last_count - steps * tps;
            end else begin
                volume     = int'(clip(longint'(volume) + moved,
                                       erv_pkg::VOL_MIN, erv_pkg::VOL_MAX));
                last_count = last_count + steps * tps;
            end
            return 1'b1;
        endfunction

        function int relay_code(int eff, int boost);
            return int'(clip(eff / 5 - 2 * boost + CODE_MAX, 0, CODE_MAX));
        endfunction

        function void record_item(erv_pkg::t_op op, logic [31:0] count,
                                  logic [15:0] vol_in);
            t_relay_codes exp_codes;
            logic chg;
            int   half, sgn, mag, hchg, lb, rb, le, re, mx, boost, left, right;
            op_seen[op]++;
            chg   = 1'b0;
            left  = 0;
            right = 0;
            case (op)
                erv_pkg::OP_ENC:  chg = encoder_move(count);
                erv_pkg::OP_MUTE: begin
                    muted = !muted;
                    chg   = 1'b1;
                end
                erv_pkg::OP_SET: begin
                    volume = int'(clip(longint'($signed(vol_in)),
                                       erv_pkg::VOL_MIN, erv_pkg::VOL_MAX));
                    chg    = 1'b1;
                end
                default: ;
            endcase
            if (!muted) begin
                half = int'(balance) / 5;
                sgn  = (half < 0) ? -1 : 1;
                mag  = half * sgn;
                hchg = sgn * (mag / 2);
                if (mag % 2 == 0) begin
                    lb = -hchg;
                    rb = hchg;
                end else if (half > 0) begin
                    lb = -hchg;
                    rb = hchg + sgn;
                end else begin
                    lb = -(hchg + sgn);
                    rb = hchg;
                end
                le = int'(clip(longint'(volume + lb * 5), erv_pkg::VOL_MIN, erv_pkg::VOL_MAX));
                re = int'(clip(longint'(volume + rb * 5), erv_pkg::VOL_MIN, erv_pkg::VOL_MAX));
                mx = (le > re) ? le : re;
                if (mx < int'(erv_pkg::GAIN_LO)) begin
                    gain_pins = erv_pkg::PINS_LOW;
                    boost     = int'(erv_pkg::BOOST_DOWN);
                end else if (mx <= 0) begin
                    gain_pins = erv_pkg::PINS_NONE;
                    boost     = 0;
                end else begin
                    gain_pins = erv_pkg::PINS_HIGH;
                    boost     = int'(erv_pkg::BOOST_UP);
                end
                left  = relay_code(le, boost);
                right = relay_code(re, boost);
                if (chan_mute == erv_pkg::CHM_LEFT)
                    left = 0;
                else if (chan_mute == erv_pkg::CHM_RIGHT)
                    right = 0;
            end
            exp_codes.left_code  = left[CODE_BITS-1:0];
            exp_codes.right_code = right[CODE_BITS-1:0];
            exp_codes.low_gain   = gain_pins[0];
            exp_codes.high_gain  = gain_pins[1];
            exp_codes.volume     = volume[erv_pkg::VOL_W-1:0];
            exp_codes.muted      = muted;
            exp_codes.changed    = chg;
            codes_due.push_back(exp_codes);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_codes(t_relay_codes got);
            t_relay_codes want;
            if (codes_due.size() == 0) begin
                errors++;
                $display("%0t ns: result beat with none pending, volume %0d", $time, got.volume);
                return;
            end
            want = codes_due.pop_front();
            checked++;
            compare_field("left_code", want.left_code, got.left_code);
            compare_field("right_code", want.right_code, got.right_code);
            compare_field("low_gain_on", want.low_gain, got.low_gain);
            compare_field("high_gain_on", want.high_gain, got.high_gain);
            compare_field("volume_now", want.volume, got.volume);
            compare_field("muted_now", want.muted, got.muted);
            compare_field("changed", want.changed, got.changed);
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic [1:0]                         i_operation;
    logic signed [erv_pkg::COUNT_W-1:0] i_encoder_count;
    logic signed [15:0]                 i_volume_value;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic [CODE_BITS-1:0]               o_left_code;
    logic [CODE_BITS-1:0]               o_right_code;
    logic                               o_low_gain_on;
    logic                               o_high_gain_on;
    logic signed [erv_pkg::VOL_W-1:0]   o_volume_now;
    logic                               o_muted_now;
    logic                               o_changed;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [erv_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [erv_pkg::CFG_DATA_W-1:0]     i_cfg_data;

    relay_scoreboard sb;
    logic            no_idle = 1'b0;
    logic            drv_muted = 1'b0;
    logic [31:0]     enc_pos = 32'd0;
    int              cur_ticks = 4;

    encoder_relay_volume_control #(
        .CODE_BITS(CODE_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_encoder_count(i_encoder_count),
        .i_volume_value (i_volume_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_code    (o_left_code),
        .o_right_code   (o_right_code),
        .o_low_gain_on  (o_low_gain_on),
        .o_high_gain_on (o_high_gain_on),
        .o_volume_now   (o_volume_now),
        .o_muted_now    (o_muted_now),
        .o_changed      (o_changed),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input erv_pkg::t_op op, input logic [31:0] cnt,
                             input logic [15:0] vol);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_encoder_count <= cnt;
        i_volume_value  <= vol;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.record_item(op, cnt, vol);
    endtask

    task automatic write_reg(input logic [erv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [erv_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle(input int tail);
        i_in_valid <= 1'b0;
        while (sb.codes_due.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic configure(input int phase);
        logic [erv_pkg::CFG_DATA_W-1:0] ticks, step, bal, chm;
        case (phase)
            0: begin
                ticks = 9'd1;
                step  = 9'd100;
                bal   = 9'(-200);
            end
            1: begin
                ticks = 9'd64;
                step  = 9'd1;
                bal   = 9'd200;
            end
            2: begin
                ticks = 9'd0;
                step  = 9'd0;
                bal   = 9'd255;
            end
            3: begin
                ticks = 9'd127;
                step  = 9'd127;
                bal   = 9'h100;
            end
            4: begin
                ticks = 9'($urandom_range(1, 64));
                step  = 9'($urandom_range(1, 100));
                bal   = 9'd25;
            end
            5: begin
                ticks = 9'($urandom_range(1, 64));
                step  = 9'($urandom_range(1, 100));
                bal   = 9'(-35);
            end
            default: begin
                ticks = 9'($urandom_range(1, 64));
                step  = 9'($urandom_range(1, 100));
                bal   = 9'($urandom_range(0, 400) - 200);
            end
        endcase
        chm       = 9'(phase % 4);
        cur_ticks = int'(ticks[6:0]);
        write_reg(erv_pkg::CFG_TICKS, ticks);
        write_reg(erv_pkg::CFG_STEP, step);
        write_reg(erv_pkg::CFG_BALANCE, bal);
        write_reg(erv_pkg::CFG_CHMUTE, chm);
    endtask

    task automatic random_item();
        int           r, k, tps, jitter;
        erv_pkg::t_op op;
        logic [31:0]  cnt;
        logic [15:0]  vol;
        cnt = $urandom;
        vol = 16'($urandom);
        r   = $urandom_range(0, 99);
        if (r < (drv_muted ? 40 : 5)) begin
            op = erv_pkg::OP_MUTE;
        end else if (r < 70) begin
            op  = erv_pkg::OP_ENC;
            tps = (cur_ticks == 0) ? 1 : cur_ticks;
            if ($urandom_range(0, 9) != 0) begin
                k       = $urandom_range(0, 6) - 3;
                jitter  = $urandom_range(0, tps - 1);
                enc_pos = enc_pos + k * tps + ($urandom_range(0, 1) ? jitter : -jitter);
            end else begin
                enc_pos = $urandom;
            end
            cnt = enc_pos;
        end else if (r < 93) begin
            op = erv_pkg::OP_SET;
            if ($urandom_range(0, 4) != 0)
                vol = 16'($urandom_range(0, 900) - 780);
        end else begin
            op = erv_pkg::OP_NONE;
        end
        if (op == erv_pkg::OP_MUTE)
            drv_muted = !drv_muted;
        send_item(op, cnt, vol);
    endtask

    // hold off results for long stretches so the block backs up into its input
    initial begin : result_sink
        int stall_left;
        int holds;
        int r;
        i_out_stall = 1'b0;
        stall_left  = 0;
        holds       = 0;
        forever begin
            @(posedge i_clk);
            if ((holds == 0 && sb.checked >= 100) || (holds == 1 && sb.checked >= 400)) begin
                stall_left = 600;
                holds++;
            end else if (stall_left == 0 && !no_idle) begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    stall_left = $urandom_range(1, 3);
                else if (r < 24)
                    stall_left = $urandom_range(10, 60);
            end
            i_out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_relay_codes got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.left_code  = o_left_code;
            got.right_code = o_right_code;
            got.low_gain   = o_low_gain_on;
            got.high_gain  = o_high_gain_on;
            got.volume     = o_volume_now;
            got.muted      = o_muted_now;
            got.changed    = o_changed;
            sb.check_codes(got);
        end
    end

    initial begin : watchdog
        #3_000_000;
        $display("Run did not finish in time, %0d results pending", sb.codes_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        sb              = new();
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_operation     = erv_pkg::OP_NONE;
        i_encoder_count = '0;
        i_volume_value  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = erv_pkg::CFG_TICKS;
        i_cfg_data      = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(erv_pkg::OP_ENC, 32'd3, 16'd0);
        send_item(erv_pkg::OP_ENC, 32'd4, 16'hFFFF);
        send_item(erv_pkg::OP_ENC, 32'd0, 16'd0);
        send_item(erv_pkg::OP_SET, 32'hFFFF_FFFF, 16'sh7FFF);
        send_item(erv_pkg::OP_SET, 32'd0, 16'sh8000);
        send_item(erv_pkg::OP_SET, 32'd0, 16'(-121));
        send_item(erv_pkg::OP_SET, 32'd0, 16'(-120));
        send_item(erv_pkg::OP_SET, 32'd0, 16'd0);
        send_item(erv_pkg::OP_SET, 32'd0, 16'd1);
        send_item(erv_pkg::OP_SET, 32'd0, 16'd120);
        send_item(erv_pkg::OP_ENC, 32'h8000_0000, 16'd0);
        send_item(erv_pkg::OP_ENC, 32'h7FFF_FFFF, 16'd0);
        send_item(erv_pkg::OP_ENC, 32'hFFFF_FFFF, 16'd0);
        send_item(erv_pkg::OP_ENC, 32'hFFFF_FFFF, 16'd0);
        send_item(erv_pkg::OP_MUTE, 32'd0, 16'd0);
        send_item(erv_pkg::OP_ENC, 32'h1234_5678, 16'd0);
        send_item(erv_pkg::OP_SET, 32'd0, 16'd50);
        send_item(erv_pkg::OP_NONE, 32'hA5A5_A5A5, 16'h5A5A);
        send_item(erv_pkg::OP_MUTE, 32'd0, 16'd0);
        send_item(erv_pkg::OP_NONE, 32'd0, 16'd0);
        send_item(erv_pkg::OP_ENC, 32'h1234_5678, 16'd0);
        enc_pos = 32'h1234_5678;
        settle(8);

        for (int phase = 0; phase < 10; phase++) begin
            configure(phase);
            no_idle = (phase == 4 || phase == 7);
            repeat (65) random_item();
            settle(8);
        end
        no_idle = 1'b0;
        settle(40);

        $display("Covered %0d encoder samples, %0d mute toggles, %0d volume sets,",
                 sb.op_seen[erv_pkg::OP_ENC], sb.op_seen[erv_pkg::OP_MUTE],
                 sb.op_seen[erv_pkg::OP_SET]);
        $display("%0d unused codes across %0d register writes; %0d beats compared, %0d failures",
                 sb.op_seen[erv_pkg::OP_NONE], sb.reg_writes, sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/erv_pkg.sv
rtl/erv_ctrl.sv
rtl/erv_dp.sv
rtl/encoder_relay_volume_control.sv
bench/encoder_relay_volume_control_tb.sv
